@@ hw/rtl/bpqrc_pkg.sv @@
// ============================================================================
// bpqrc_pkg
// Types and constants shared by the buffer-driven PI quantizer controller.
// ============================================================================
package bpqrc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 28;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_MODE  = 3'd0,
        REG_TARGET_BPS = 3'd1,
        REG_BITS_FRAME = 3'd2,
        REG_BUCKET     = 3'd3,
        REG_START_QP   = 3'd4,
        REG_QP_FLOOR   = 3'd5,
        REG_QP_CEIL    = 3'd6
    } t_reg_idx;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam logic [1:0] MODE_VBR = 2'd1;
    localparam logic [1:0] MODE_LL  = 2'd2;
    localparam logic       ACT_REQ  = 1'b0;

    typedef struct packed {
        logic        action;
        logic [31:0] frame_sad;
        logic [30:0] frame_bits;
        logic [31:0] elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  frame_qp;
        logic [27:0] bucket_level;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [27:0] data;
    } t_cfg_item;

endpackage

@@ hw/rtl/bpqrc_if.sv @@
// ============================================================================
// bpqrc_if
// Valid/ready channel carrying one payload of a generic type.
// ============================================================================
interface bpqrc_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/buffer_pi_qp_rate_controller_unit.sv @@
// Steps: a quantizer request passes S_MUL, S_DIV, S_REQ_FIN and S_OUT; a frame report
// runs a serial multiply in S_MUL, then S_DIV, S_RPT_FIN and S_OUT, on one shared serial
// multiply/divide unit working one bit per cycle. Only one request is in flight; the next
// is taken in S_IDLE after the result is handed off in S_OUT.
// Reset (synchronous, active low) loads the register defaults and bucket = half size.
// A config write is taken only while idle; indices 0-6 reload the state in the same cycle.
// ============================================================================
// buffer_pi_qp_rate_controller_unit
// Leaky-bucket PI quantizer controller with serial arithmetic.
// ============================================================================
module buffer_pi_qp_rate_controller_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bpqrc_if.sink   i_cfg,
    bpqrc_if.sink   i_req,
    bpqrc_if.source o_res
);
    import bpqrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_REQ_FIN, S_RPT_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic [1:0]  r_mode;
    logic [27:0] r_tbps, r_bpf, r_bsize;
    logic [5:0]  r_sqp, r_qmin, r_qmax;
    logic [27:0] r_fill;
    logic signed [35:0] r_esum;
    logic [5:0]  r_qp;
    logic [31:0] r_last_sad;

    t_in_item    r_item;
    // serial unit: r_acc holds product/remainder, r_mcand the other operand
    logic [63:0] r_acc;
    logic [63:0] r_mcand;
    logic [63:0] r_quo;
    logic [6:0]  r_cnt;
    logic        r_neg;
    logic [5:0]  r_oqp;
    logic [27:0] r_ofill;

    logic [26:0] w_half;
    logic signed [37:0] w_err;
    logic signed [37:0] w_cap;
    logic signed [37:0] w_esum_add;
    logic signed [35:0] w_esum_new;
    logic signed [43:0] w_num;
    logic [43:0] w_mag;
    logic [33:0] w_den2;
    logic        w_sat;

    assign w_half = (r_bsize[27:1] == 27'd0) ? 27'd1 : r_bsize[27:1];
    assign w_err  = 38'(signed'({10'd0, r_fill})) - 38'(signed'({11'd0, w_half}));
    assign w_cap  = 38'(signed'({11'd0, w_half})) * 38'sd150;
    assign w_sat  = ((r_qp >= r_qmax) && (w_err > 0)) || ((r_qp <= r_qmin) && (w_err < 0));
    assign w_esum_add = 38'(r_esum) + w_err;
    always_comb begin
        if (w_sat) begin
            w_esum_new = r_esum;
        end else if (w_esum_add > w_cap) begin
            w_esum_new = 36'(w_cap);
        end else if (w_esum_add < -w_cap) begin
            w_esum_new = 36'(-w_cap);
        end else begin
            w_esum_new = 36'(w_esum_add);
        end
    end
    assign w_num = 44'(w_err) * 44'sd90 + 44'(w_esum_new) * 44'sd4;
    assign w_mag = w_num[43] ? 44'(-w_num) : 44'(w_num);
    assign w_den2 = 34'({7'd0, w_half}) * 34'd30;

    // request finish
    logic signed [9:0] w_adj, w_step, w_lim, w_qn;
    logic [35:0] w_s10, w_l13, w_l7;
    assign w_s10 = 36'(r_item.frame_sad) * 36'd10;
    assign w_l13 = 36'(r_last_sad) * 36'd13;
    assign w_l7  = 36'(r_last_sad) * 36'd7;
    always_comb begin
        w_adj = r_neg ? -10'(signed'({1'b0, r_quo[8:0]})) : 10'(signed'({1'b0, r_quo[8:0]}));
        if (r_quo[63:9] != '0) w_adj = r_neg ? -10'sd300 : 10'sd300;
        if (r_mode == MODE_VBR && r_last_sad != '0) begin
            if (w_s10 > w_l13) w_adj = w_adj + 10'sd2;
            else if (w_s10 < w_l7) w_adj = w_adj - 10'sd2;
        end
        w_lim  = (r_mode == MODE_LL) ? 10'sd3 : 10'sd2;
        w_step = 10'(signed'({4'd0, r_sqp})) + w_adj - 10'(signed'({4'd0, r_qp}));
        if (w_step > w_lim) w_step = w_lim;
        if (w_step < -w_lim) w_step = -w_lim;
        w_qn = 10'(signed'({4'd0, r_qp})) + w_step;
        if (w_qn < 10'(signed'({4'd0, r_qmin}))) w_qn = 10'(signed'({4'd0, r_qmin}));
        if (w_qn > 10'(signed'({4'd0, r_qmax}))) w_qn = 10'(signed'({4'd0, r_qmax}));
    end

    // report finish: drain in r_quo
    logic signed [33:0] w_fsum;
    logic [27:0] w_drain;
    assign w_drain = (r_item.elapsed_us == '0) ? r_bpf : r_quo[27:0];
    assign w_fsum  = 34'(signed'({6'd0, r_fill})) + 34'(signed'({3'd0, r_item.frame_bits}))
                   - 34'(signed'({6'd0, w_drain}));

    logic [64:0] w_trial;
    assign w_trial = {r_acc, r_quo[63]} - {1'b0, r_mcand};

    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_req.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign o_res.valid = (r_state == S_OUT);
    assign o_res.data  = '{frame_qp: r_oqp, bucket_level: r_ofill};

    function automatic logic [17:0] w_tclamp_in(input logic [31:0] us);
        if (us < 32'd1000) return 18'd1000;
        if (us > 32'd250000) return 18'd250000;
        return 18'(us);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= 2'd0;
            r_tbps  <= 28'd5000000;
            r_bpf   <= 28'd83333;
            r_bsize <= 28'd5000000;
            r_sqp   <= 6'd26;
            r_qmin  <= 6'd12;
            r_qmax  <= 6'd51;
            r_fill  <= 28'd2500000;
            r_esum  <= '0;
            r_qp    <= 6'd26;
            r_last_sad <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_reg_idx'(i_cfg.data.index))
                REG_RATE_MODE: r_mode <= i_cfg.data.data[1:0];
                REG_TARGET_BPS: r_tbps <= i_cfg.data.data;
                REG_BITS_FRAME: r_bpf <= i_cfg.data.data;
                REG_BUCKET: r_bsize <= i_cfg.data.data;
                REG_START_QP: r_sqp <= i_cfg.data.data[5:0];
                REG_QP_FLOOR: r_qmin <= i_cfg.data.data[5:0];
                REG_QP_CEIL: r_qmax <= i_cfg.data.data[5:0];
                default: ;
            endcase
            if (i_cfg.data.index <= REG_QP_CEIL) begin
                r_fill <= (i_cfg.data.index == REG_BUCKET) ? 28'(i_cfg.data.data[27:1])
                                                           : 28'(r_bsize[27:1]);
                r_esum <= '0;
                r_qp <= (i_cfg.data.index == REG_START_QP) ? i_cfg.data.data[5:0] : r_sqp;
                r_last_sad <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_item <= i_req.data;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_item.action == ACT_REQ) begin
                        // (2*mag + den) / (2*den)
                        r_esum  <= w_esum_new;
                        r_neg   <= w_num[43];
                        r_quo   <= 64'({w_mag, 1'b0}) + 64'(w_den2 >> 1);
                        r_mcand <= 64'(w_den2);
                        r_acc   <= '0;
                        r_cnt   <= 7'd64;
                        r_state <= S_DIV;
                    end else begin
                        // serial multiply: tbps * t, one bit a cycle
                        if (r_cnt == 7'd0) begin
                            r_quo   <= r_acc;
                            r_acc   <= '0;
                            r_mcand <= 64'd1000000;
                            r_cnt   <= 7'd64;
                            r_state <= S_DIV;
                        end else begin
                            if (r_quo[0]) r_acc <= r_acc + r_mcand;
                            r_quo   <= r_quo >> 1;
                            r_mcand <= r_mcand << 1;
                            r_cnt   <= r_cnt - 7'd1;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == 7'd0) begin
                        r_state <= (r_item.action == ACT_REQ) ? S_REQ_FIN : S_RPT_FIN;
                    end else begin
                        if (!w_trial[64]) begin
                            r_acc <= w_trial[63:0];
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_acc <= {r_acc[62:0], r_quo[63]};
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                S_REQ_FIN: begin
                    r_qp <= w_qn[5:0];
                    r_oqp <= w_qn[5:0];
                    r_ofill <= r_fill;
                    r_last_sad <= r_item.frame_sad;
                    r_state <= S_OUT;
                end
                S_RPT_FIN: begin
                    if (w_fsum < 0) begin
                        r_fill <= '0; r_ofill <= '0;
                    end else if (w_fsum > 34'(signed'({6'd0, r_bsize}))) begin
                        r_fill <= r_bsize; r_ofill <= r_bsize;
                    end else begin
                        r_fill <= w_fsum[27:0]; r_ofill <= w_fsum[27:0];
                    end
                    r_oqp <= r_qp;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE && i_req.valid) begin
                r_acc   <= '0;
                r_quo   <= 64'(w_tclamp_in(i_req.data.elapsed_us));
                r_mcand <= 64'(r_tbps);
                r_cnt   <= 7'd18;
            end
        end
    end

    a_qp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REQ_FIN && r_qmin <= r_qmax) |=> (r_oqp >= r_qmin && r_oqp <= r_qmax))
        else $error("qp out of range");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && $past(r_state) == S_RPT_FIN) |-> (r_ofill <= r_bsize))
        else $error("fill beyond bucket");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready)
        else $error("accept while busy");
endmodule
